FILE: hw/rtl/efr_pkg.sv
// efr_pkg: shared constants, types and register codes for the escaped frame receiver.
// Used by efr_cell, efr_chain and escaped_frame_receiver; depends on nothing.
`timescale 1ns / 1ps

package efr_pkg;

   localparam int MAX_FRAME_BYTES = 64;
   localparam int BYTE_W          = 8;
   localparam int IDX_W           = 6;
   localparam int LEN_W           = 7;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 2'd2;

   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd19;
   localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd20;
   localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd21;

   typedef enum logic {
      ST_RECV,
      ST_DRAIN
   } efr_state_type;

   // Control broadcast to every cell of the payload chain.
   typedef struct packed {
      logic              clear;
      logic              shift;
      logic              write;
      logic [BYTE_W-1:0] wr_byte;
   } cell_ctrl_type;

endpackage

FILE: hw/rtl/efr_cell.sv
// efr_cell: one payload byte of the store chain, with its occupancy bit.
// Depends on efr_pkg (cell_ctrl_type, BYTE_W).
`timescale 1ns / 1ps

module efr_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  efr_pkg::cell_ctrl_type     ctrl,
   input  logic                       left_valid,
   input  logic [efr_pkg::BYTE_W-1:0] right_data,
   input  logic                       right_valid,
   output logic [efr_pkg::BYTE_W-1:0] data,
   output logic                       valid
);

   logic [efr_pkg::BYTE_W-1:0] data_ff, data_in;
   logic                       valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         // advance toward the head
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.write && !valid_ff && left_valid) begin
         // first empty cell takes the byte
         data_in  = ctrl.wr_byte;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

FILE: hw/rtl/efr_chain.sv
// efr_chain: row of efr_cell instances holding one frame's payload in order.
// Depends on efr_pkg and efr_cell; cell 0 is the head that readout takes from.
`timescale 1ns / 1ps

module efr_chain (
   input  logic                                  clock,
   input  logic                                  reset,
   input  efr_pkg::cell_ctrl_type                ctrl,
   output logic [efr_pkg::BYTE_W-1:0]            head_data,
   output logic [efr_pkg::MAX_FRAME_BYTES-1:0]   occupied
);

   localparam int N = efr_pkg::MAX_FRAME_BYTES;

   logic [efr_pkg::BYTE_W-1:0] cell_data [N];
   logic [N-1:0]               cell_valid;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                       lv;
      logic [efr_pkg::BYTE_W-1:0] rd;
      logic                       rv;

      if (i == 0) begin : g_head
         assign lv = 1'b1;
      end else begin : g_body
         assign lv = cell_valid[i-1];
      end

      if (i == N-1) begin : g_tail
         assign rd = '0;
         assign rv = 1'b0;
      end else begin : g_inner
         assign rd = cell_data[i+1];
         assign rv = cell_valid[i+1];
      end

      efr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_valid  (lv),
         .right_data  (rd),
         .right_valid (rv),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   assign head_data = cell_data[0];
   assign occupied  = cell_valid;

endmodule

FILE: hw/rtl/escaped_frame_receiver.sv
// escaped_frame_receiver: top level; byte decoder, frame control and readout.
// Depends on efr_pkg and efr_chain (which holds the efr_cell row).
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  req_    | in        | req_valid/req_stall | req_rx_byte[7:0]
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_frame_byte, rsp_byte_index,
//          |           |                     | rsp_frame_length, rsp_last
//  csr_    | in        | csr_valid/csr_ready | csr_index[1:0], csr_wdata[7:0]
//
// A closing end code hands the stored frame of N bytes to readout, which shifts the
// payload chain one cell per cycle into the output register while rsp_stall does not
// hold it. req_stall is high during readout. Synchronous active-high reset clears the
// codes to 19/20/21 and empties the chain at once; no clearing pass. csr_ready is
// always high.

module escaped_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   // received bytes
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [efr_pkg::BYTE_W-1:0]          req_rx_byte,
   // frame payload results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [efr_pkg::BYTE_W-1:0]          rsp_frame_byte,
   output logic [efr_pkg::IDX_W-1:0]           rsp_byte_index,
   output logic [efr_pkg::LEN_W-1:0]           rsp_frame_length,
   output logic                                rsp_last,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [efr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [efr_pkg::BYTE_W-1:0]          csr_wdata
);

   localparam logic [efr_pkg::LEN_W-1:0] FULL_COUNT =
      efr_pkg::LEN_W'(efr_pkg::MAX_FRAME_BYTES);

   // ---------------------------------------------------------------- registers
   efr_pkg::efr_state_type          state_ff, state_in;
   logic [efr_pkg::BYTE_W-1:0]      esc_code_ff, esc_code_in;
   logic [efr_pkg::BYTE_W-1:0]      start_code_ff, start_code_in;
   logic [efr_pkg::BYTE_W-1:0]      end_code_ff, end_code_in;
   logic                            pend_ff, pend_in;
   logic                            open_ff, open_in;
   logic [efr_pkg::LEN_W-1:0]       fill_ff, fill_in;
   logic [efr_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [efr_pkg::IDX_W-1:0]       rd_idx_ff, rd_idx_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [efr_pkg::BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [efr_pkg::IDX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [efr_pkg::LEN_W-1:0]       rsp_len_ff, rsp_len_in;
   logic                            rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- decode
   logic                               req_xfer;
   logic                               csr_xfer;
   logic                               is_esc, is_start, is_end;
   logic                               take_lit;
   logic                               close_go;
   logic                               rsp_load;
   logic                               drain_last;
   efr_pkg::cell_ctrl_type             chain_ctrl;
   logic [efr_pkg::BYTE_W-1:0]         head_data;
   logic [efr_pkg::MAX_FRAME_BYTES-1:0] occupied;

   assign req_stall = (state_ff != efr_pkg::ST_RECV);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   // Escape test comes first, so a doubled escape always yields a literal escape;
   // the start meaning wins over the end meaning when both codes match.
   assign is_esc   = (req_rx_byte == esc_code_ff);
   assign is_start = (req_rx_byte == start_code_ff);
   assign is_end   = (req_rx_byte == end_code_ff);

   // Literal byte: a doubled escape, an escape before an ordinary byte, or a plain byte.
   assign take_lit = req_xfer && ((is_esc && pend_ff) ||
                                  (!is_esc && !(pend_ff && (is_start || is_end))));

   // Close with a non-empty open frame hands over to readout.
   assign close_go = req_xfer && !is_esc && pend_ff && !is_start && is_end &&
                     open_ff && (fill_ff != '0);

   // Output register frees up when empty or when its result is being taken.
   assign rsp_load   = (state_ff == efr_pkg::ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign drain_last = ({1'b0, rd_idx_ff} + efr_pkg::LEN_W'(1)) == len_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efr_pkg::ST_RECV: begin
            if (close_go) begin
               state_in = efr_pkg::ST_DRAIN;
            end
         end
         efr_pkg::ST_DRAIN: begin
            if (rsp_load && drain_last) begin
               state_in = efr_pkg::ST_RECV;
            end
         end
         default: state_in = efr_pkg::ST_RECV;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      esc_code_in   = esc_code_ff;
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      pend_in       = pend_ff;
      open_in       = open_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;

      chain_ctrl         = '0;
      chain_ctrl.wr_byte = req_rx_byte;

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;

      // register writes; unknown index is dropped
      if (csr_xfer) begin
         unique case (csr_index)
            efr_pkg::CSR_ESCAPE_CODE: esc_code_in   = csr_wdata;
            efr_pkg::CSR_START_CODE:  start_code_in = csr_wdata;
            efr_pkg::CSR_END_CODE:    end_code_in   = csr_wdata;
            default: ;
         endcase
      end

      if (req_xfer) begin
         // hold a lone escape, drop it on anything that follows
         pend_in = is_esc && !pend_ff;
         if (!is_esc && pend_ff && is_start) begin
            // open, or restart an open frame empty
            open_in          = 1'b1;
            fill_in          = '0;
            chain_ctrl.clear = 1'b1;
         end else if (!is_esc && pend_ff && is_end) begin
            if (open_ff) begin
               open_in   = 1'b0;
               fill_in   = '0;
               len_in    = fill_ff;
               rd_idx_in = '0;
            end
         end
      end

      if (take_lit && open_ff) begin
         if (fill_ff == FULL_COUNT) begin
            // store full: abort the frame and drop the byte
            open_in          = 1'b0;
            fill_in          = '0;
            chain_ctrl.clear = 1'b1;
         end else begin
            chain_ctrl.write = 1'b1;
            fill_in          = fill_ff + efr_pkg::LEN_W'(1);
         end
      end

      // readout: advance the chain one cell into the output register
      if (rsp_load) begin
         chain_ctrl.shift = 1'b1;
         rsp_byte_in      = head_data;
         rsp_idx_in       = rd_idx_ff;
         rsp_len_in       = len_ff;
         rsp_last_in      = drain_last;
         rd_idx_in        = rd_idx_ff + efr_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= efr_pkg::ST_RECV;
         esc_code_ff   <= efr_pkg::ESCAPE_CODE_RST;
         start_code_ff <= efr_pkg::START_CODE_RST;
         end_code_ff   <= efr_pkg::END_CODE_RST;
         pend_ff       <= 1'b0;
         open_ff       <= 1'b0;
         fill_ff       <= '0;
         rd_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         esc_code_ff   <= esc_code_in;
         start_code_ff <= start_code_in;
         end_code_ff   <= end_code_in;
         pend_ff       <= pend_in;
         open_ff       <= open_in;
         fill_ff       <= fill_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   efr_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .head_data (head_data),
      .occupied  (occupied)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_frame_length = rsp_len_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   // While receiving, the chain holds exactly the bytes counted in the fill count.
   a_fill_matches_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efr_pkg::ST_RECV) |-> ($countones(occupied) == int'(fill_ff)))
      else $error("chain occupancy differs from fill count");

   // During readout the chain head always carries a stored byte.
   a_head_valid_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efr_pkg::ST_DRAIN) |-> occupied[0])
      else $error("readout ran past the stored frame");

   // Readout starts only after the frame was closed and its count cleared.
   a_drain_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efr_pkg::ST_DRAIN) |-> (!open_ff && fill_ff == '0 && len_ff != '0))
      else $error("readout with a frame still open");

   // The final byte of a run returns control to receiving.
   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && drain_last) |=> (state_ff == efr_pkg::ST_RECV && occupied == '0))
      else $error("chain not empty after final readout");

endmodule
